>>> rtl/adf_pkg.sv
// shared types, character codes and float constants for the decimal text to float32 converter
package adf_pkg;

	typedef enum logic [3:0] {
		DOP_INT_MUL  = 4'd0,
		DOP_INT_ADD  = 4'd1,
		DOP_FRAC_MUL = 4'd2,
		DOP_FRAC_ADD = 4'd3,
		DOP_DIVS_MUL = 4'd4,
		DOP_FIN_DIV  = 4'd5,
		DOP_FIN_ADD  = 4'd6,
		DOP_POW      = 4'd7,
		DOP_SCALE    = 4'd8
	} dop_t;

	typedef enum logic [1:0] {
		FOP_ADD = 2'd0,
		FOP_MUL = 2'd1,
		FOP_DIV = 2'd2
	} fop_t;

	typedef struct packed {
		logic       start;
		dop_t       op;
		logic       scale_div;
		logic       clear;
		logic       dig_load;
		logic [3:0] dig;
		logic       exp_add;
		logic       v_init;
		logic       pow_init;
		logic       out_load;
		logic       out_neg;
	} dp_cmd_t;

	typedef struct packed {
		logic done;
		logic pow_zero;
		logic p_inf;
	} dp_sts_t;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_E_LO  = 8'h65;
	localparam logic [7:0] CH_E_UP  = 8'h45;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [31:0] F_ZERO = 32'h0000_0000;
	localparam logic [31:0] F_ONE  = 32'h3F80_0000;
	localparam logic [31:0] F_TEN  = 32'h4120_0000;
	localparam logic [31:0] F_QNAN = 32'h7FC0_0000;
	localparam logic [30:0] F_INF  = 31'h7F80_0000;

	function automatic logic [31:0] digit_to_float(input logic [3:0] d);
		logic [31:0] f;
		case (d)
			4'd1: f = 32'h3F80_0000;
			4'd2: f = 32'h4000_0000;
			4'd3: f = 32'h4040_0000;
			4'd4: f = 32'h4080_0000;
			4'd5: f = 32'h40A0_0000;
			4'd6: f = 32'h40C0_0000;
			4'd7: f = 32'h40E0_0000;
			4'd8: f = 32'h4100_0000;
			4'd9: f = 32'h4110_0000;
			default: f = F_ZERO;
		endcase
		return f;
	endfunction

endpackage

>>> rtl/adf_fpu.sv
// multi-cycle float32 add, multiply and divide unit with round to nearest even
module adf_fpu
	import adf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  fop_t        op,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic        done,
	output logic [31:0] result
);

	typedef enum logic [6:0] {
		F_IDLE = 7'b0000001,
		F_MUL  = 7'b0000010,
		F_ADD  = 7'b0000100,
		F_PRE  = 7'b0001000,
		F_DIV  = 7'b0010000,
		F_NORM = 7'b0100000,
		F_DONE = 7'b1000000
	} fst_t;

	fst_t st_q, st_d;

	logic        sa, sb, a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
	logic [23:0] ma, mb;
	logic signed [11:0] ea, eb;
	logic        spec;
	logic [31:0] spec_val;
	logic        a_big;

	logic [23:0] ma_q, mb_q;
	logic signed [11:0] ex_q, eb_q, ne_q;
	logic        sign_q, sub_q, nst_q;
	logic [7:0]  d_q;
	logic [49:0] nm_q;
	logic [24:0] r_q;
	logic [5:0]  cnt_q;
	logic [31:0] res_q;

	logic [47:0] prod;
	logic [49:0] sx, sh, bx;
	logic        stk;
	logic [50:0] sum;
	logic        ge;
	logic [24:0] rd;
	logic        g, st_b, rnd;
	logic [7:0]  ef;
	logic [30:0] packed_v;

	// operand unpack
	assign sa     = a[31];
	assign sb     = b[31];
	assign a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
	assign b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
	assign a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
	assign b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
	assign a_zero = (a[30:0] == 31'd0);
	assign b_zero = (b[30:0] == 31'd0);
	assign ma     = {(a[30:23] != 8'd0), a[22:0]};
	assign mb     = {(b[30:23] != 8'd0), b[22:0]};
	assign ea     = {4'd0, (a[30:23] == 8'd0) ? 8'd1 : a[30:23]};
	assign eb     = {4'd0, (b[30:23] == 8'd0) ? 8'd1 : b[30:23]};
	assign a_big  = (a[30:0] >= b[30:0]);

	always_comb begin
		spec     = 1'b0;
		spec_val = F_ZERO;
		case (op)
			FOP_MUL: begin
				if (a_nan || b_nan || (a_inf && b_zero) || (a_zero && b_inf)) begin
					spec     = 1'b1;
					spec_val = F_QNAN;
				end else if (a_inf || b_inf) begin
					spec     = 1'b1;
					spec_val = {sa ^ sb, F_INF};
				end else if (a_zero || b_zero) begin
					spec     = 1'b1;
					spec_val = {sa ^ sb, 31'd0};
				end
			end
			FOP_DIV: begin
				if (a_nan || b_nan || (a_zero && b_zero) || (a_inf && b_inf)) begin
					spec     = 1'b1;
					spec_val = F_QNAN;
				end else if (a_inf || b_zero) begin
					spec     = 1'b1;
					spec_val = {sa ^ sb, F_INF};
				end else if (a_zero || b_inf) begin
					spec     = 1'b1;
					spec_val = {sa ^ sb, 31'd0};
				end
			end
			FOP_ADD: begin
				if (a_nan || b_nan || (a_inf && b_inf && (sa != sb))) begin
					spec     = 1'b1;
					spec_val = F_QNAN;
				end else if (a_inf) begin
					spec     = 1'b1;
					spec_val = a;
				end else if (b_inf) begin
					spec     = 1'b1;
					spec_val = b;
				end else if (a_zero && b_zero) begin
					spec     = 1'b1;
					spec_val = {sa & sb, 31'd0};
				end
			end
			default: begin
				spec     = 1'b1;
				spec_val = F_QNAN;
			end
		endcase
	end

	// product
	assign prod = 48'(ma_q) * 48'(mb_q);

	// alignment and add
	assign sx = {1'b0, mb_q, 25'd0};
	assign bx = {1'b0, ma_q, 25'd0};
	always_comb begin
		if (d_q >= 8'd50) begin
			sh  = 50'd0;
			stk = |mb_q;
		end else begin
			sh  = sx >> d_q;
			stk = |(sx & ~({50{1'b1}} << d_q));
		end
		if (sub_q) begin
			sum = {bx, 1'b0} - {sh, stk};
		end else begin
			sum = {bx, 1'b0} + {sh, stk};
		end
	end

	// restoring divide step
	assign ge = (r_q >= {1'b0, mb_q});
	assign rd = ge ? (r_q - {1'b0, mb_q}) : r_q;

	// rounding
	assign g        = nm_q[24];
	assign st_b     = (|nm_q[23:0]) | nst_q;
	assign rnd      = g & (st_b | nm_q[25]);
	assign ef       = nm_q[48] ? ne_q[7:0] : 8'd0;
	assign packed_v = {ef, nm_q[47:25]} + {30'd0, rnd};

	always_comb begin
		st_d = st_q;
		case (st_q)
			F_IDLE: begin
				if (start) begin
					if (spec) begin
						st_d = F_DONE;
					end else begin
						case (op)
							FOP_MUL: st_d = F_MUL;
							FOP_ADD: st_d = F_ADD;
							default: st_d = F_PRE;
						endcase
					end
				end
			end
			F_MUL:  st_d = F_NORM;
			F_ADD:  st_d = F_NORM;
			F_PRE: begin
				if (ma_q[23] && mb_q[23]) begin
					st_d = F_DIV;
				end
			end
			F_DIV: begin
				if (cnt_q == 6'd0) begin
					st_d = F_NORM;
				end
			end
			F_NORM: begin
				if ((nm_q == 50'd0) && !nst_q) begin
					st_d = F_DONE;
				end else if (!(ne_q < -12'sd30) && !nm_q[49] && !(ne_q < 12'sd1)
					&& !(!nm_q[48] && (ne_q > 12'sd1))) begin
					st_d = F_DONE;
				end
			end
			F_DONE:  st_d = F_IDLE;
			default: st_d = F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= F_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			F_IDLE: begin
				if (start) begin
					if (spec) begin
						res_q <= spec_val;
					end else begin
						case (op)
							FOP_MUL: begin
								ma_q   <= ma;
								mb_q   <= mb;
								ne_q   <= ea + eb - 12'sd127;
								sign_q <= sa ^ sb;
							end
							FOP_ADD: begin
								ma_q   <= a_big ? ma : mb;
								mb_q   <= a_big ? mb : ma;
								ne_q   <= a_big ? ea : eb;
								d_q    <= a_big ? (ea[7:0] - eb[7:0]) : (eb[7:0] - ea[7:0]);
								sub_q  <= sa ^ sb;
								sign_q <= a_big ? sa : sb;
							end
							default: begin
								ma_q   <= ma;
								mb_q   <= mb;
								ex_q   <= ea;
								eb_q   <= eb;
								sign_q <= sa ^ sb;
							end
						endcase
					end
				end
			end
			F_MUL: begin
				nm_q  <= {prod, 2'b00};
				nst_q <= 1'b0;
			end
			F_ADD: begin
				nm_q  <= sum[50:1];
				nst_q <= sum[0];
			end
			F_PRE: begin
				if (!ma_q[23]) begin
					ma_q <= {ma_q[22:0], 1'b0};
					ex_q <= ex_q - 12'sd1;
				end else if (!mb_q[23]) begin
					mb_q <= {mb_q[22:0], 1'b0};
					eb_q <= eb_q - 12'sd1;
				end else begin
					r_q   <= {1'b0, ma_q};
					ne_q  <= ex_q - eb_q + 12'sd126;
					cnt_q <= 6'd49;
					nm_q  <= 50'd0;
				end
			end
			F_DIV: begin
				r_q   <= {rd[23:0], 1'b0};
				nm_q  <= {nm_q[48:0], ge};
				cnt_q <= cnt_q - 6'd1;
				nst_q <= (rd != 25'd0);
			end
			F_NORM: begin
				if ((nm_q == 50'd0) && !nst_q) begin
					res_q <= F_ZERO;
				end else if (ne_q < -12'sd30) begin
					// far below the smallest subnormal
					nm_q  <= 50'd0;
					nst_q <= 1'b1;
					ne_q  <= 12'sd1;
				end else if (nm_q[49] || (ne_q < 12'sd1)) begin
					nm_q  <= {1'b0, nm_q[49:1]};
					nst_q <= nst_q | nm_q[0];
					ne_q  <= ne_q + 12'sd1;
				end else if (!nm_q[48] && (ne_q > 12'sd1)) begin
					nm_q <= {nm_q[48:0], 1'b0};
					ne_q <= ne_q - 12'sd1;
				end else if (ne_q > 12'sd254) begin
					res_q <= {sign_q, F_INF};
				end else begin
					res_q <= {sign_q, packed_v};
				end
			end
			default: begin
			end
		endcase
	end

	assign done   = (st_q == F_DONE);
	assign result = res_q;

endmodule

>>> rtl/adf_datapath.sv
// accumulator registers, exponent counter, power register and float unit of the converter
module adf_datapath
	import adf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     cmd,
	output dp_sts_t     sts,
	output logic [31:0] value_bits
);

	logic [31:0] int_q, frac_q, divs_q, v_q, p_q, out_q;
	logic [7:0]  exp_q, cnt_q;
	logic [3:0]  dig_q;
	logic [31:0] dig_f;
	logic [31:0] opa, opb, fres;
	fop_t        fop;
	logic        fdone;
	logic [11:0] ev;
	logic        v_nan;

	assign dig_f = digit_to_float(dig_q);

	always_comb begin
		opa = int_q;
		opb = F_TEN;
		fop = FOP_MUL;
		case (cmd.op)
			DOP_INT_MUL: begin
				opa = int_q;
				opb = F_TEN;
				fop = FOP_MUL;
			end
			DOP_INT_ADD: begin
				opa = int_q;
				opb = dig_f;
				fop = FOP_ADD;
			end
			DOP_FRAC_MUL: begin
				opa = frac_q;
				opb = F_TEN;
				fop = FOP_MUL;
			end
			DOP_FRAC_ADD: begin
				opa = frac_q;
				opb = dig_f;
				fop = FOP_ADD;
			end
			DOP_DIVS_MUL: begin
				opa = divs_q;
				opb = F_TEN;
				fop = FOP_MUL;
			end
			DOP_FIN_DIV: begin
				opa = frac_q;
				opb = divs_q;
				fop = FOP_DIV;
			end
			DOP_FIN_ADD: begin
				opa = int_q;
				opb = v_q;
				fop = FOP_ADD;
			end
			DOP_POW: begin
				opa = p_q;
				opb = F_TEN;
				fop = FOP_MUL;
			end
			DOP_SCALE: begin
				opa = v_q;
				opb = p_q;
				fop = cmd.scale_div ? FOP_DIV : FOP_MUL;
			end
			default: begin
			end
		endcase
	end

	adf_fpu u_fpu (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.start),
		.op     (fop),
		.a      (opa),
		.b      (opb),
		.done   (fdone),
		.result (fres)
	);

	// exponent digits, saturating at 255
	assign ev = ({4'd0, exp_q} << 3) + ({4'd0, exp_q} << 1) + {8'd0, cmd.dig};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			int_q  <= F_ZERO;
			frac_q <= F_ZERO;
			divs_q <= F_ONE;
			exp_q  <= 8'd0;
		end else if (cmd.clear) begin
			int_q  <= F_ZERO;
			frac_q <= F_ZERO;
			divs_q <= F_ONE;
			exp_q  <= 8'd0;
		end else begin
			if (cmd.exp_add) begin
				exp_q <= (ev > 12'd255) ? 8'hFF : ev[7:0];
			end
			if (fdone) begin
				case (cmd.op)
					DOP_INT_MUL, DOP_INT_ADD:   int_q  <= fres;
					DOP_FRAC_MUL, DOP_FRAC_ADD: frac_q <= fres;
					DOP_DIVS_MUL:               divs_q <= fres;
					default: begin
					end
				endcase
			end
		end
	end

	assign v_nan = (v_q[30:23] == 8'hFF) && (v_q[22:0] != 23'd0);

	always_ff @(posedge clk) begin
		if (cmd.dig_load) begin
			dig_q <= cmd.dig;
		end
		if (cmd.v_init) begin
			v_q <= int_q;
		end
		if (cmd.pow_init) begin
			p_q   <= F_ONE;
			cnt_q <= exp_q;
		end
		if (fdone) begin
			case (cmd.op)
				DOP_FIN_DIV, DOP_FIN_ADD, DOP_SCALE: v_q <= fres;
				DOP_POW: begin
					p_q   <= fres;
					cnt_q <= cnt_q - 8'd1;
				end
				default: begin
				end
			endcase
		end
		if (cmd.out_load) begin
			out_q <= v_nan ? F_QNAN : {v_q[31] ^ cmd.out_neg, v_q[30:0]};
		end
	end

	assign sts.done     = fdone;
	assign sts.pow_zero = (cnt_q == 8'd0);
	assign sts.p_inf    = (p_q[30:0] == F_INF);
	assign value_bits   = out_q;

endmodule

>>> rtl/adf_ctrl.sv
// parse phase tracking and operation sequencer of the converter
module adf_ctrl
	import adf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       char_valid,
	output logic       char_stall,
	input  logic [7:0] char_code,
	input  logic       is_last,
	output logic       value_valid,
	input  logic       value_stall,
	output dp_cmd_t    cmd,
	input  dp_sts_t    sts
);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_OP   = 6'b000010,
		S_FIN  = 6'b000100,
		S_EXP  = 6'b001000,
		S_PCHK = 6'b010000,
		S_OUT  = 6'b100000
	} st_t;

	typedef enum logic [5:0] {
		PH_SPACE   = 6'b000001,
		PH_INT     = 6'b000010,
		PH_FRAC    = 6'b000100,
		PH_EXPSIGN = 6'b001000,
		PH_EXPDIG  = 6'b010000,
		PH_DONE    = 6'b100000
	} ph_t;

	st_t  st_q, st_d;
	ph_t  ph_q, ph_d;
	dop_t op_q, op_d;
	logic issued_q, issued_d, last_q, last_d;
	logic mneg_q, mneg_d, fseen_q, fseen_d, eneg_q, eneg_d, edig_q, edig_d;
	logic out_valid_q;
	logic acc, go, out_free;
	logic is_dig, is_e, is_sp, is_minus, is_plus, is_dot, int_act;

	assign acc      = char_valid && (st_q == S_IDLE);
	assign out_free = !out_valid_q || !value_stall;

	assign is_dig   = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
	assign is_e     = (char_code == CH_E_LO) || (char_code == CH_E_UP);
	assign is_sp    = (char_code == CH_SPACE) || (char_code == CH_TAB);
	assign is_minus = (char_code == CH_MINUS);
	assign is_plus  = (char_code == CH_PLUS);
	assign is_dot   = (char_code == CH_DOT);
	assign int_act  = (ph_q == PH_INT)
		|| ((ph_q == PH_SPACE) && !is_sp && !is_minus && !is_plus);

	always_comb begin
		st_d          = st_q;
		ph_d          = ph_q;
		op_d          = op_q;
		issued_d      = issued_q;
		last_d        = last_q;
		mneg_d        = mneg_q;
		fseen_d       = fseen_q;
		eneg_d        = eneg_q;
		edig_d        = edig_q;
		go            = 1'b0;
		cmd           = '0;
		cmd.op        = op_q;
		cmd.scale_div = eneg_q;
		cmd.dig       = char_code[3:0];
		cmd.out_neg   = mneg_q;
		case (st_q)
			S_IDLE: begin
				if (acc) begin
					if (int_act) begin
						ph_d = PH_INT;
						if (is_dig) begin
							go   = 1'b1;
							op_d = DOP_INT_MUL;
						end else if (is_dot) begin
							fseen_d = 1'b1;
							ph_d    = PH_FRAC;
						end else if (is_e) begin
							ph_d = PH_EXPSIGN;
						end else begin
							ph_d = PH_DONE;
						end
					end else begin
						case (ph_q)
							PH_SPACE: begin
								if (is_minus) begin
									mneg_d = 1'b1;
									ph_d   = PH_INT;
								end else if (is_plus) begin
									ph_d = PH_INT;
								end
							end
							PH_FRAC: begin
								if (is_dig) begin
									go   = 1'b1;
									op_d = DOP_FRAC_MUL;
								end else if (is_e) begin
									ph_d = PH_EXPSIGN;
								end else begin
									ph_d = PH_DONE;
								end
							end
							PH_EXPSIGN: begin
								if (is_minus) begin
									eneg_d = 1'b1;
									ph_d   = PH_EXPDIG;
								end else if (is_plus) begin
									ph_d = PH_EXPDIG;
								end else if (is_dig) begin
									cmd.exp_add = 1'b1;
									edig_d      = 1'b1;
									ph_d        = PH_EXPDIG;
								end else begin
									ph_d = PH_DONE;
								end
							end
							PH_EXPDIG: begin
								if (is_dig) begin
									cmd.exp_add = 1'b1;
									edig_d      = 1'b1;
								end else begin
									ph_d = PH_DONE;
								end
							end
							default: begin
							end
						endcase
					end
					if (go) begin
						cmd.dig_load = 1'b1;
						st_d         = S_OP;
						issued_d     = 1'b0;
						last_d       = is_last;
					end else if (is_last) begin
						st_d = S_FIN;
					end
				end
			end
			S_OP: begin
				cmd.start = !issued_q;
				issued_d  = 1'b1;
				if (sts.done) begin
					issued_d = 1'b0;
					case (op_q)
						DOP_INT_MUL:  op_d = DOP_INT_ADD;
						DOP_FRAC_MUL: op_d = DOP_FRAC_ADD;
						DOP_FRAC_ADD: op_d = DOP_DIVS_MUL;
						DOP_INT_ADD, DOP_DIVS_MUL: st_d = last_q ? S_FIN : S_IDLE;
						DOP_FIN_DIV:  op_d = DOP_FIN_ADD;
						DOP_FIN_ADD:  st_d = S_EXP;
						DOP_POW:      st_d = S_PCHK;
						default:      st_d = S_OUT;
					endcase
				end
			end
			S_FIN: begin
				if (fseen_q) begin
					op_d = DOP_FIN_DIV;
					st_d = S_OP;
				end else begin
					cmd.v_init = 1'b1;
					st_d       = S_EXP;
				end
			end
			S_EXP: begin
				if (edig_q) begin
					cmd.pow_init = 1'b1;
					st_d         = S_PCHK;
				end else begin
					st_d = S_OUT;
				end
			end
			S_PCHK: begin
				op_d = (sts.pow_zero || sts.p_inf) ? DOP_SCALE : DOP_POW;
				st_d = S_OP;
			end
			S_OUT: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					cmd.clear    = 1'b1;
					ph_d         = PH_SPACE;
					mneg_d       = 1'b0;
					fseen_d      = 1'b0;
					eneg_d       = 1'b0;
					edig_d       = 1'b0;
					last_d       = 1'b0;
					st_d         = S_IDLE;
				end
			end
			default: st_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			ph_q        <= PH_SPACE;
			op_q        <= DOP_INT_MUL;
			issued_q    <= 1'b0;
			last_q      <= 1'b0;
			mneg_q      <= 1'b0;
			fseen_q     <= 1'b0;
			eneg_q      <= 1'b0;
			edig_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			st_q     <= st_d;
			ph_q     <= ph_d;
			op_q     <= op_d;
			issued_q <= issued_d;
			last_q   <= last_d;
			mneg_q   <= mneg_d;
			fseen_q  <= fseen_d;
			eneg_q   <= eneg_d;
			edig_q   <= edig_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!value_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign char_stall  = (st_q != S_IDLE);
	assign value_valid = out_valid_q;

`ifndef SYNTHESIS
	a_done_in_op: assert property (@(posedge clk) disable iff (!arst_n)
		sts.done |-> (st_q == S_OP))
		else $error("float unit finished outside an operation");
	a_last_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(char_valid && !char_stall && is_last) |=> (st_q != S_IDLE))
		else $error("last request did not start a result");
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || !value_stall))
		else $error("result overwritten before taken");
`endif

endmodule

>>> rtl/ascii_decimal_to_float32_top.sv
// a space, sign, point or exponent character is taken without a float operation
// an integer digit takes two float ops and a fraction digit three, all on the shared unit
// subnormal operands add one-bit normalize steps to an operation
// after the last character: the fraction divide when a point was seen, one multiply per power of ten,
// then a multiply to scale the value, or a divide when the exponent is negative
// reset is asynchronous, active low: back to leading whitespace, accumulators cleared, no result held
module ascii_decimal_to_float32_top
	import adf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        char_valid,
	output logic        char_stall,
	input  logic [7:0]  char_code,
	input  logic        is_last,
	output logic        value_valid,
	input  logic        value_stall,
	output logic [31:0] value_bits
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	adf_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.char_valid  (char_valid),
		.char_stall  (char_stall),
		.char_code   (char_code),
		.is_last     (is_last),
		.value_valid (value_valid),
		.value_stall (value_stall),
		.cmd         (cmd),
		.sts         (sts)
	);

	adf_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.value_bits (value_bits)
	);

endmodule
